@@ rtl/core/paged_word_byte_memory_access_core_defines.svh @@
// assertion macros shared by the paged memory core
`ifndef PAGED_WORD_BYTE_MEMORY_ACCESS_CORE_DEFINES_SVH
`define PAGED_WORD_BYTE_MEMORY_ACCESS_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define PWBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define PWBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pwbm_pkg.sv @@
package pwbm_pkg;

  // geometry
  localparam int BLOCKS        = 16;
  localparam int PAGES         = 16;
  localparam int PHYS_SEGMENTS = 32;
  localparam int SEGMENT_WORDS = 4096;

  // field widths
  localparam int DATA_W = 16;
  localparam int ADDR_W = 16;
  localparam int BLK_W  = 4;
  localparam int PAGE_W = 4;
  localparam int SEG_W  = 5;
  localparam int OFS_W  = $clog2(SEGMENT_WORDS);
  localparam int TOP_BIT = 15;

  // page map and physical memory sizes
  localparam int MAP_DEPTH  = BLOCKS * PAGES;
  localparam int MAP_AW     = $clog2(MAP_DEPTH);
  localparam int PHYS_DEPTH = PHYS_SEGMENTS * SEGMENT_WORDS;
  localparam int PHYS_AW    = $clog2(PHYS_DEPTH);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // op codes
  localparam logic [2:0] OP_MAP_LOAD   = 3'd0;
  localparam logic [2:0] OP_READ_WORD  = 3'd1;
  localparam logic [2:0] OP_WRITE_WORD = 3'd2;
  localparam logic [2:0] OP_READ_BYTE  = 3'd3;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROM_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROM_SEG    = 2'd2;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_RD_WORD,
    KIND_WR_WORD,
    KIND_RD_BYTE,
    KIND_WR_BYTE
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_MEM
  } bk_state_t;

  typedef struct packed {
    logic             mod_mode;
    logic             prom_enable;
    logic [SEG_W-1:0] prom_segment;
  } cfg_t;

  // translated access handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic               hit;
    logic               blk0;
    logic               prom;
    logic               used;
    logic               hi_byte;
    logic [PHYS_AW-1:0] paddr;
    logic [DATA_W-1:0]  wdata;
  } qent_t;

  typedef struct packed {
    logic              extra_bit_used;
    logic              alarm;
    logic              no_mem_irq;
    logic [DATA_W-1:0] read_data;
    logic              ok;
  } result_t;

endpackage

@@ rtl/core/pwbm_front.sv @@
`include "paged_word_byte_memory_access_core_defines.svh"

module pwbm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pwbm_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     op,
  input  logic [pwbm_pkg::BLK_W-1:0]     block,
  input  logic [pwbm_pkg::ADDR_W-1:0]    address,
  input  logic [pwbm_pkg::DATA_W-1:0]    write_data,
  input  logic                           extra_bit,
  input  logic [pwbm_pkg::PAGE_W-1:0]    map_page,
  input  logic                           map_valid,
  input  logic [pwbm_pkg::SEG_W-1:0]     map_segment,
  output logic                           q_push,
  output pwbm_pkg::qent_t                q_din,
  input  logic                           q_full
);

  typedef struct packed {
    pwbm_pkg::kind_t                 kind;
    logic                            blk_ok;
    logic                            blk0;
    logic                            set;
    logic                            used;
    logic                            hi_byte;
    logic [pwbm_pkg::OFS_W-1:0]      ofs;
    logic [pwbm_pkg::DATA_W-1:0]     wdata;
  } fst_t;

  logic [pwbm_pkg::SEG_W:0]          map_mem [pwbm_pkg::MAP_DEPTH];
  logic [pwbm_pkg::MAP_DEPTH-1:0]    map_set_r;
  logic [pwbm_pkg::MAP_DEPTH-1:0]    map_set_nxt;
  logic [pwbm_pkg::SEG_W:0]          map_rd_r;
  logic                              st_vld_r;
  logic                              st_vld_nxt;
  fst_t                              st_r;
  fst_t                              st_nxt;
  logic                              accept;
  logic                              blk_ok;
  logic                              is_byte;
  logic                              map_we;
  logic [pwbm_pkg::ADDR_W-1:0]       waddr;
  logic [pwbm_pkg::MAP_AW-1:0]       map_ra;
  logic [pwbm_pkg::MAP_AW-1:0]       map_wa;
  pwbm_pkg::kind_t                   kind;
  logic [pwbm_pkg::SEG_W-1:0]        seg;

  // handshake: stage takes an item when empty or when it moves on
  assign in_ready = !st_vld_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = st_vld_r && !q_full;

  // classify the op
  always_comb begin
    case (op)
      pwbm_pkg::OP_READ_WORD:  kind = pwbm_pkg::KIND_RD_WORD;
      pwbm_pkg::OP_WRITE_WORD: kind = pwbm_pkg::KIND_WR_WORD;
      pwbm_pkg::OP_READ_BYTE:  kind = pwbm_pkg::KIND_RD_BYTE;
      pwbm_pkg::OP_WRITE_BYTE: kind = pwbm_pkg::KIND_WR_BYTE;
      default:                 kind = pwbm_pkg::KIND_NONE;
    endcase
  end

  // word address, with bit 15 from extra_bit for byte access in mod mode
  assign is_byte = (kind == pwbm_pkg::KIND_RD_BYTE) || (kind == pwbm_pkg::KIND_WR_BYTE);
  assign waddr   = is_byte ? {cfg.mod_mode & extra_bit, address[pwbm_pkg::ADDR_W-1:1]}
                           : address;
  assign blk_ok  = ({1'b0, block} < (pwbm_pkg::BLK_W + 1)'(pwbm_pkg::BLOCKS));
  assign map_ra  = pwbm_pkg::MAP_AW'({block, waddr[pwbm_pkg::TOP_BIT -: pwbm_pkg::PAGE_W]});
  assign map_wa  = pwbm_pkg::MAP_AW'({block, map_page});
  assign map_we  = accept && (op == pwbm_pkg::OP_MAP_LOAD) && blk_ok;

  // stage contents
  always_comb begin
    st_vld_nxt = st_vld_r;
    st_nxt     = st_r;
    if (accept) begin
      st_vld_nxt     = 1'b1;
      st_nxt.kind    = kind;
      st_nxt.blk_ok  = blk_ok;
      st_nxt.blk0    = (block == '0);
      st_nxt.set     = map_set_r[map_ra];
      st_nxt.used    = is_byte && cfg.mod_mode;
      st_nxt.hi_byte = !address[0];
      st_nxt.ofs     = waddr[pwbm_pkg::OFS_W-1:0];
      st_nxt.wdata   = write_data;
    end else if (q_push) begin
      st_vld_nxt = 1'b0;
    end
  end

  // written marks of the page map
  always_comb begin
    map_set_nxt = map_set_r;
    if (map_we) begin
      map_set_nxt[map_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r  <= 1'b0;
      map_set_r <= '0;
    end else begin
      st_vld_r  <= st_vld_nxt;
      map_set_r <= map_set_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  // page map memory, registered read
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= {map_valid, map_segment};
    end
    if (accept) begin
      map_rd_r <= map_mem[map_ra];
    end
  end

  // translate into a physical address
  assign seg = map_rd_r[pwbm_pkg::SEG_W-1:0];

  always_comb begin
    q_din.kind    = st_r.kind;
    q_din.hit     = st_r.blk_ok && st_r.set && map_rd_r[pwbm_pkg::SEG_W]
                    && ({4'b0, seg} < (pwbm_pkg::SEG_W + 4)'(pwbm_pkg::PHYS_SEGMENTS));
    q_din.blk0    = st_r.blk0;
    q_din.prom    = cfg.prom_enable && (seg == cfg.prom_segment);
    q_din.used    = st_r.used;
    q_din.hi_byte = st_r.hi_byte;
    q_din.paddr   = pwbm_pkg::PHYS_AW'({seg, st_r.ofs});
    q_din.wdata   = st_r.wdata;
  end

  `PWBM_ASSERT_NEXT(a_stage_holds, st_vld_r && q_full, st_vld_r && $stable(st_r),
                    "front stage changed while the queue was full")

endmodule

@@ rtl/core/pwbm_queue.sv @@
`include "paged_word_byte_memory_access_core_defines.svh"

module pwbm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pwbm_pkg::qent_t din,
  output logic            full,
  input  logic            pop,
  output pwbm_pkg::qent_t dout,
  output logic            empty
);

  pwbm_pkg::qent_t                 slot_r [pwbm_pkg::QUEUE_DEPTH];
  logic [pwbm_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [pwbm_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [pwbm_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [pwbm_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [pwbm_pkg::QCNT_W-1:0]     count_r;
  logic [pwbm_pkg::QCNT_W-1:0]     count_nxt;

  assign full  = (count_r == pwbm_pkg::QCNT_W'(pwbm_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pwbm_pkg::QPTR_W'(pwbm_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_r + pwbm_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pwbm_pkg::QPTR_W'(pwbm_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_r + pwbm_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + pwbm_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - pwbm_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  `PWBM_ASSERT_NEXT(a_queue_fill, push && !pop,
                    count_r == $past(count_r) + pwbm_pkg::QCNT_W'(1),
                    "queue fill count did not follow a push")

endmodule

@@ rtl/core/pwbm_back.sv @@
`include "paged_word_byte_memory_access_core_defines.svh"

module pwbm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  pwbm_pkg::qent_t   q_dout,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pwbm_pkg::result_t out_res
);

  logic [pwbm_pkg::DATA_W-1:0]   phys_mem [pwbm_pkg::PHYS_DEPTH];
  pwbm_pkg::bk_state_t           state_r;
  pwbm_pkg::bk_state_t           state_nxt;
  pwbm_pkg::qent_t               cur_r;
  logic [pwbm_pkg::DATA_W-1:0]   mem_rd_r;
  logic                          out_vld_r;
  logic                          out_vld_nxt;
  pwbm_pkg::result_t             out_res_r;
  pwbm_pkg::result_t             res_nxt;
  logic                          res_ld;
  logic                          out_free;
  logic                          need_rd;
  logic                          is_access;
  logic                          mem_re;
  logic                          mem_we;
  logic [pwbm_pkg::PHYS_AW-1:0]  mem_wa;
  logic [pwbm_pkg::DATA_W-1:0]   mem_wd;
  logic [pwbm_pkg::DATA_W-1:0]   merged;

  assign out_free  = !out_vld_r || out_ready;
  assign is_access = (q_dout.kind != pwbm_pkg::KIND_NONE);
  assign need_rd   = q_dout.hit && ((q_dout.kind == pwbm_pkg::KIND_RD_WORD)
                                 || (q_dout.kind == pwbm_pkg::KIND_RD_BYTE)
                                 || (q_dout.kind == pwbm_pkg::KIND_WR_BYTE));

  // byte merge for a read-modify-write
  assign merged = cur_r.hi_byte ? {cur_r.wdata[7:0], mem_rd_r[7:0]}
                                : {mem_rd_r[15:8], cur_r.wdata[7:0]};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pwbm_pkg::BK_IDLE: begin
        if (!q_empty && out_free && need_rd) begin
          state_nxt = pwbm_pkg::BK_MEM;
        end
      end
      pwbm_pkg::BK_MEM: begin
        if (out_free) begin
          state_nxt = pwbm_pkg::BK_IDLE;
        end
      end
      default: state_nxt = pwbm_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop   = 1'b0;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = q_dout.paddr;
    mem_wd  = q_dout.wdata;
    res_ld  = 1'b0;
    res_nxt = '0;
    case (state_r)
      pwbm_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop  = 1'b1;
          mem_re = need_rd;
          mem_we = q_dout.hit && !q_dout.prom && (q_dout.kind == pwbm_pkg::KIND_WR_WORD);
          res_ld = !need_rd;
          res_nxt.ok             = !(is_access && !q_dout.hit && q_dout.blk0);
          res_nxt.no_mem_irq     = is_access && !q_dout.hit;
          res_nxt.alarm          = is_access && !q_dout.hit && q_dout.blk0;
          res_nxt.extra_bit_used = q_dout.used;
        end
      end
      pwbm_pkg::BK_MEM: begin
        if (out_free) begin
          res_ld = 1'b1;
          mem_we = !cur_r.prom && (cur_r.kind == pwbm_pkg::KIND_WR_BYTE);
          mem_wa = cur_r.paddr;
          mem_wd = merged;
          res_nxt.ok             = 1'b1;
          res_nxt.extra_bit_used = cur_r.used;
          case (cur_r.kind)
            pwbm_pkg::KIND_RD_WORD: res_nxt.read_data = mem_rd_r;
            pwbm_pkg::KIND_RD_BYTE: res_nxt.read_data = {8'h00, cur_r.hi_byte ? mem_rd_r[15:8]
                                                                         : mem_rd_r[7:0]};
            default:                res_nxt.read_data = '0;
          endcase
        end
      end
      default: begin
        res_ld = 1'b0;
      end
    endcase
  end

  assign out_vld_nxt = res_ld || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pwbm_pkg::BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // current item and output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_dout;
    end
    if (res_ld) begin
      out_res_r <= res_nxt;
    end
  end

  // physical word memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      phys_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= phys_mem[q_dout.paddr];
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  `PWBM_ASSERT_SAME(a_mem_phase_mapped, state_r == pwbm_pkg::BK_MEM, cur_r.hit,
                    "memory phase entered for an unmapped access")
  `PWBM_ASSERT_NEXT(a_mem_phase_result, (state_r == pwbm_pkg::BK_MEM) && out_free, out_vld_r,
                    "memory phase finished without a result")

endmodule

@@ rtl/core/paged_word_byte_memory_access_core.sv @@
// Paged word/byte memory unit. Each input item either loads one entry of the 16 x 16 page
// map or reads or writes one word or byte of the 128K-word physical memory, and gives exactly
// one result item. The front stage decodes the op, builds the word address and reads the page
// map (registered map read); a two-entry queue then hands the translated access to the back
// end, which owns the single physical memory port. In the back end a map load, an unmapped
// access or a word write finishes in the idle state; a word read, a byte read or a byte write
// also passes through the memory state, since the memory read is registered and a byte write
// then writes the merged word there. Sustained rate is one item per cycle for the short ops
// while results are taken; reads and byte writes hold the back end in its memory state before
// it takes the next item. Page map entries come out of reset unmapped through per-entry valid
// flops, so no clearing pass runs after reset; physical memory is not initialized.
module paged_word_byte_memory_access_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [pwbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwbm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // block[3:0] address[19:4] write_data[35:20] extra_bit[36] map_page[40:37]
  // map_valid[41] map_segment[46:42], zero pad[47]
  input  logic [47:0]                        in_tdata,
  // op[2:0]
  input  logic [2:0]                         in_tuser,
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // ok[0] read_data[16:1] no_mem_irq[17] alarm[18] extra_bit_used[19], zero pad[23:20]
  output logic [23:0]                        out_tdata
);

  pwbm_pkg::cfg_t     cfg_r;
  pwbm_pkg::cfg_t     cfg_nxt;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  pwbm_pkg::qent_t    q_din;
  pwbm_pkg::qent_t    q_dout;
  pwbm_pkg::result_t  res;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pwbm_pkg::CFG_MOD_MODE:    cfg_nxt.mod_mode     = cfg_wdata[0];
        pwbm_pkg::CFG_PROM_ENABLE: cfg_nxt.prom_enable  = cfg_wdata[0];
        pwbm_pkg::CFG_PROM_SEG:    cfg_nxt.prom_segment = cfg_wdata[pwbm_pkg::SEG_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // decode, map lookup and translation
  pwbm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser),
    .block       (in_tdata[3:0]),
    .address     (in_tdata[19:4]),
    .write_data  (in_tdata[35:20]),
    .extra_bit   (in_tdata[36]),
    .map_page    (in_tdata[40:37]),
    .map_valid   (in_tdata[41]),
    .map_segment (in_tdata[46:42]),
    .q_push      (q_push),
    .q_din       (q_din),
    .q_full      (q_full)
  );

  // decoupling queue
  pwbm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // physical memory access and result register
  pwbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // result packing
  assign out_tdata = {4'b0000, res.extra_bit_used, res.alarm, res.no_mem_irq,
                      res.read_data, res.ok};

endmodule
